/* rtl/core/assert_macros.svh */
// Assertion macros shared by the contour metric RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CMS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("contour metric assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("contour metric assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("contour metric assertion failed");

`endif

/* rtl/core/cms_pkg.sv */
// Types and constants shared by the contour metric modules.
`default_nettype none

package cms_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned METRIC_W    = 12;
  localparam int unsigned WIDTH_W     = 13;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 13'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 16'd480;
  localparam logic [PIX_W-1:0]    MIN_MASK_RESET = 8'd0;

  // Output queue; two results may enter in one cycle.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_MIN_MASK     = 2'd2
  } cfg_reg_e;

  // One window column: pixels of the top, middle and bottom rows.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // One line store entry.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
    logic [PIX_W-1:0] mask;
  } line_t;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic                frame_last;
  } res_t;

  // Position flags of the item held in the compute stage.
  typedef struct packed {
    logic valid;
    logic draining;
    logic col_ge1;
    logic col_eq1;
    logic col_last;
    logic row_ge1;
    logic row_le1;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cms_intf.sv */
// Channel interfaces of the contour metric block: pixels, results, configuration.
`default_nettype none

interface cms_pix_if;
  logic                         valid;
  logic                         ready;
  logic [cms_pkg::PIX_W-1:0]    pixel_value;
  logic [cms_pkg::PIX_W-1:0]    mask_value;
  logic                         drain;

  modport source (output valid, pixel_value, mask_value, drain, input ready);
  modport sink (input valid, pixel_value, mask_value, drain, output ready);
endinterface

interface cms_res_if;
  logic                         valid;
  logic                         ready;
  logic [cms_pkg::METRIC_W-1:0] metric;
  logic                         frame_last;

  modport source (output valid, metric, frame_last, input ready);
  modport sink (input valid, metric, frame_last, output ready);
endinterface

interface cms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cms_pkg::CFG_INDEX_W-1:0] index;
  logic [cms_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/cms_line_mem.sv */
// Line store memory: upper row, middle row and mask byte per column.
`default_nettype none

module cms_line_mem #(
  parameter int unsigned DEPTH = cms_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  cms_pkg::line_t         wr_data_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output cms_pkg::line_t         rd_data_o
);

  cms_pkg::line_t mem_q [DEPTH];
  cms_pkg::line_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/core/cms_scan.sv */
// Raster position counters and the compute stage's position flags.
`default_nettype none

module cms_scan #(
  parameter int unsigned MAX_WIDTH = cms_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [cms_pkg::WIDTH_W-1:0]      image_width_i,
  input  logic [cms_pkg::HEIGHT_W-1:0]     image_height_i,
  input  logic                             accept_i,
  input  logic                             drain_i,
  output logic                             rd_en_o,
  output logic [AW-1:0]                    rd_addr_o,
  output cms_pkg::scan_ctl_t               ctl_o,
  output logic [AW-1:0]                    addr_o
);

  localparam int unsigned WW = (AW + 1 > cms_pkg::WIDTH_W) ? AW + 1 : cms_pkg::WIDTH_W;

  logic [WW-1:0]                width_ext;
  logic [AW-1:0]                last_col;
  logic [AW-1:0]                col_sel;
  logic [AW-1:0]                col_q, col_d;
  logic [cms_pkg::HEIGHT_W-1:0] row_q, row_d;
  logic [cms_pkg::HEIGHT_W-1:0] height_eff;
  logic                         draining;
  logic                         take;
  cms_pkg::scan_ctl_t           ctl_q, ctl_d;
  logic [AW-1:0]                addr_q;

  always_comb begin
    width_ext = WW'(image_width_i);
    if (width_ext < WW'(2)) begin
      last_col = AW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      last_col = AW'(MAX_WIDTH - 1);
    end else begin
      last_col = AW'(width_ext - WW'(1));
    end

    height_eff = (image_height_i == '0) ? cms_pkg::HEIGHT_W'(1) : image_height_i;
    draining   = row_q >= height_eff;
    // A drain item ahead of the flush row is accepted and thrown away.
    take       = accept_i && !(drain_i && !draining);
    // A column count left beyond a narrowed width ends the row.
    col_sel    = (col_q > last_col) ? last_col : col_q;

    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (col_sel == last_col) begin
        col_d = '0;
        row_d = draining ? '0 : row_q + cms_pkg::HEIGHT_W'(1);
      end else begin
        col_d = col_sel + AW'(1);
      end
    end

    ctl_d.valid    = take;
    ctl_d.draining = draining;
    ctl_d.col_ge1  = col_sel != '0;
    ctl_d.col_eq1  = col_sel == AW'(1);
    ctl_d.col_last = col_sel == last_col;
    ctl_d.row_ge1  = row_q != '0;
    ctl_d.row_le1  = row_q <= cms_pkg::HEIGHT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ctl_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      addr_q <= col_sel;
    end
  end

  assign rd_en_o   = take;
  assign rd_addr_o = col_sel;
  assign ctl_o     = ctl_q;
  assign addr_o    = addr_q;

endmodule

`default_nettype wire

/* rtl/core/cms_grad.sv */
// Sobel gradient magnitudes and direction bit for one 3x3 window.
`default_nettype none

module cms_grad (
  input  cms_pkg::col_t                 left_i,
  input  cms_pkg::col_t                 center_i,
  input  cms_pkg::col_t                 right_i,
  input  logic [cms_pkg::PIX_W-1:0]     mask_i,
  input  logic [cms_pkg::PIX_W-1:0]     min_mask_i,
  output logic [cms_pkg::METRIC_W-1:0]  metric_o
);

  logic [9:0]  sum_l, sum_r, sum_t, sum_b;
  logic [9:0]  dx, dy;
  logic [10:0] mag;

  always_comb begin
    sum_l = 10'(left_i.top) + {1'b0, left_i.mid, 1'b0} + 10'(left_i.bot);
    sum_r = 10'(right_i.top) + {1'b0, right_i.mid, 1'b0} + 10'(right_i.bot);
    sum_t = 10'(left_i.top) + {1'b0, center_i.top, 1'b0} + 10'(right_i.top);
    sum_b = 10'(left_i.bot) + {1'b0, center_i.bot, 1'b0} + 10'(right_i.bot);

    dx  = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
    dy  = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
    mag = 11'(dx) + 11'(dy);

    if (mask_i < min_mask_i) begin
      metric_o = '0;
    end else begin
      metric_o = {mag, dx < dy};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cms_out_fifo.sv */
// Result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module cms_out_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_a_i,
  input  cms_pkg::res_t              data_a_i,
  input  logic                       push_b_i,
  input  cms_pkg::res_t              data_b_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output cms_pkg::res_t              data_o,
  output logic [cms_pkg::FIFO_AW:0]  count_o
);

  localparam int unsigned AW = cms_pkg::FIFO_AW;

  cms_pkg::res_t  slot_q [cms_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [AW:0]    count_q, count_d;
  logic [AW-1:0]  addr_b;

  // Result A is older than result B when both arrive together.
  assign addr_b = push_a_i ? wr_ptr_q + AW'(1) : wr_ptr_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_a_i) + AW'(push_b_i);
    rd_ptr_d = rd_ptr_q + AW'(pop_i);
    count_d  = count_q + (AW+1)'(push_a_i) + (AW+1)'(push_b_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      slot_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      slot_q[addr_b] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = count_q != '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

/* rtl/core/contour_metric_sobel.sv */
// Top level of the streaming 3x3 Sobel contour metric block.
`default_nettype none

`include "assert_macros.svh"

// Takes one pixel per clock in raster order and gives the contour metric of each
// position, one row and one column behind the input, with a final row of drain
// items flushing the bottom row. An accepted item reads the line memory at its
// column; in the next cycle the window and both Sobel sums are formed from that
// registered read, and the results enter an eight-entry output queue, whose head
// drives the output. The last item of a row yields two results, and a row of items
// yields one row of results, so the sustained rate is one item per clock while the
// output takes one result per clock. The input stalls only while the output queue
// cannot take the results still in flight. The line memory needs no clearing pass
// after reset.
module contour_metric_sobel #(
  parameter int unsigned MAX_WIDTH = cms_pkg::MAX_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cms_cfg_if.sink   cfg_i,
  cms_pix_if.sink   pix_i,
  cms_res_if.source res_o
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W = cms_pkg::FIFO_AW + 2;

  logic [cms_pkg::WIDTH_W-1:0]  width_q;
  logic [cms_pkg::HEIGHT_W-1:0] height_q;
  logic [cms_pkg::PIX_W-1:0]    min_mask_q;

  logic                         pix_accept;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                st_addr;
  cms_pkg::scan_ctl_t           ctl;
  cms_pkg::line_t               rd_data;
  cms_pkg::line_t               wr_data;
  logic                         wr_en;

  logic [cms_pkg::PIX_W-1:0]    pix_q;
  logic [cms_pkg::PIX_W-1:0]    mask_q;
  cms_pkg::col_t                win0_q, win1_q;
  logic [cms_pkg::PIX_W-1:0]    mask_dly_q;

  cms_pkg::col_t                cur;
  cms_pkg::col_t                left_a;
  logic [cms_pkg::METRIC_W-1:0] metric_a, metric_b;
  cms_pkg::res_t                res_a, res_b;
  logic                         push_a, push_b;
  logic                         res_pop;
  cms_pkg::res_t                res_head;
  logic                         res_valid;
  logic [cms_pkg::FIFO_AW:0]    fifo_count;
  logic [CNT_W-1:0]             fill_need;

  // Configuration registers; the user must make writes arrive only while the block is idle, unchecked by the block.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= cms_pkg::WIDTH_RESET;
      height_q   <= cms_pkg::HEIGHT_RESET;
      min_mask_q <= cms_pkg::MIN_MASK_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        cms_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= cfg_i.data[cms_pkg::WIDTH_W-1:0];
        end
        cms_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= cfg_i.data[cms_pkg::HEIGHT_W-1:0];
        end
        cms_pkg::CFG_MIN_MASK: begin
          min_mask_q <= cfg_i.data[cms_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Accept only when the queue can hold what is in flight plus two more results.
  assign fill_need  = CNT_W'(fifo_count) + CNT_W'(push_a) + CNT_W'(push_b) + CNT_W'(2);
  assign pix_i.ready = fill_need <= CNT_W'(cms_pkg::FIFO_DEPTH);
  assign pix_accept  = pix_i.valid && pix_i.ready;

  cms_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .accept_i       (pix_accept),
    .drain_i        (pix_i.drain),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .ctl_o          (ctl),
    .addr_o         (st_addr)
  );

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      pix_q  <= pix_i.pixel_value;
      mask_q <= pix_i.mask_value;
    end
  end

  // The middle row moves up and the new pixel becomes the middle row.
  assign wr_en          = ctl.valid && !ctl.draining;
  assign wr_data.upper  = rd_data.middle;
  assign wr_data.middle = pix_q;
  assign wr_data.mask   = mask_q;

  cms_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (st_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Top and bottom rows are replicated at the frame borders.
  always_comb begin
    cur.top = ctl.row_le1 ? rd_data.middle : rd_data.upper;
    cur.mid = rd_data.middle;
    cur.bot = ctl.draining ? rd_data.middle : pix_q;
    left_a  = ctl.col_eq1 ? win0_q : win1_q;
  end

  cms_grad u_grad_a (
    .left_i     (left_a),
    .center_i   (win0_q),
    .right_i    (cur),
    .mask_i     (mask_dly_q),
    .min_mask_i (min_mask_q),
    .metric_o   (metric_a)
  );

  // At the right edge the last column also serves as its own right neighbor.
  cms_grad u_grad_b (
    .left_i     (win0_q),
    .center_i   (cur),
    .right_i    (cur),
    .mask_i     (rd_data.mask),
    .min_mask_i (min_mask_q),
    .metric_o   (metric_b)
  );

  assign push_a           = ctl.valid && ctl.row_ge1 && ctl.col_ge1;
  assign push_b           = ctl.valid && ctl.row_ge1 && ctl.col_last;
  assign res_a.metric     = metric_a;
  assign res_a.frame_last = 1'b0;
  assign res_b.metric     = metric_b;
  assign res_b.frame_last = ctl.draining;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q     <= '0;
      win1_q     <= '0;
      mask_dly_q <= '0;
    end else if (ctl.valid) begin
      win1_q     <= win0_q;
      win0_q     <= cur;
      mask_dly_q <= rd_data.mask;
    end
  end

  cms_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .data_a_i (res_a),
    .push_b_i (push_b),
    .data_b_i (res_b),
    .pop_i    (res_pop),
    .valid_o  (res_valid),
    .data_o   (res_head),
    .count_o  (fifo_count)
  );

  assign res_o.valid      = res_valid;
  assign res_o.metric     = res_head.metric;
  assign res_o.frame_last = res_head.frame_last;
  assign res_pop          = res_o.valid && res_o.ready;

  `CMS_ASSERT_ALWAYS(a_fifo_bound, clk_i, rst_ni, fifo_count <= (cms_pkg::FIFO_AW+1)'(cms_pkg::FIFO_DEPTH))
  `CMS_ASSERT_NEXT(a_item_enters, clk_i, rst_ni, rd_en, ctl.valid)
  `CMS_ASSERT_IMPLY(a_no_rw_clash, clk_i, rst_ni, wr_en && rd_en, st_addr != rd_addr)

endmodule

`default_nettype wire

/* tb/tb_contour_metric_sobel.sv */
`timescale 1ns / 100ps
// Self-checking testbench for contour_metric_sobel: random pixel frames against a metric predictor.

module tb_contour_metric_sobel;

  localparam int unsigned RAND_ITEMS  = 1550;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_PAD  = 8;
  localparam int unsigned PRINT_MAX   = 50;

  typedef struct packed {
    logic [cms_pkg::PIX_W-1:0] pixel;
    logic [cms_pkg::PIX_W-1:0] mask;
    logic                      drain;
  } pix_item_t;

  logic clk = 1'b0;
  logic rst_n;

  cms_cfg_if cfg_if ();
  cms_pix_if pix_if ();
  cms_res_if res_if ();

  contour_metric_sobel i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if.sink),
    .pix_i (pix_if.sink),
    .res_o (res_if.source)
  );

  always #2 clk = ~clk;

  // Register copies, updated when a configuration transaction is accepted.
  logic [cms_pkg::WIDTH_W-1:0]  cfg_width    = cms_pkg::WIDTH_RESET;
  logic [cms_pkg::HEIGHT_W-1:0] cfg_height   = cms_pkg::HEIGHT_RESET;
  logic [cms_pkg::PIX_W-1:0]    cfg_min_mask = cms_pkg::MIN_MASK_RESET;

  // Predictor state.
  logic [cms_pkg::PIX_W-1:0] upper_mem  [cms_pkg::MAX_WIDTH_DEF];
  logic [cms_pkg::PIX_W-1:0] middle_mem [cms_pkg::MAX_WIDTH_DEF];
  logic [cms_pkg::PIX_W-1:0] maskrow_mem[cms_pkg::MAX_WIDTH_DEF];
  cms_pkg::col_t             win_col[2];
  logic [cms_pkg::PIX_W-1:0] mask_dly  = '0;
  int unsigned               col_pos   = 0;
  int unsigned               row_pos   = 0;
  cms_pkg::res_t             metric_pending[$];

  // Stimulus state: the generator tracks the scan position on its own.
  pix_item_t   pix_pending[$];
  int unsigned gen_col      = 0;
  int unsigned gen_row      = 0;
  int unsigned items_made   = 0;
  bit          pix_idle_on  = 1'b1;
  bit          res_idle_on  = 1'b1;
  bit          hold_go      = 1'b0;
  bit          hold_res     = 1'b0;
  int unsigned pix_wait     = 0;
  int unsigned res_wait     = 0;
  bit          pix_taken    = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned mismatches   = 0;

  function automatic int unsigned eff_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > cms_pkg::MAX_WIDTH_DEF) return cms_pkg::MAX_WIDTH_DEF;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  function automatic logic [cms_pkg::METRIC_W-1:0] sobel_metric(
    cms_pkg::col_t l, cms_pkg::col_t ce, cms_pkg::col_t r, logic [cms_pkg::PIX_W-1:0] mk);
    int gx, gy;
    gx = (int'(r.top) + 2 * int'(r.mid) + int'(r.bot))
       - (int'(l.top) + 2 * int'(l.mid) + int'(l.bot));
    gy = (int'(l.bot) + 2 * int'(ce.bot) + int'(r.bot))
       - (int'(l.top) + 2 * int'(ce.top) + int'(r.top));
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    if (mk < cfg_min_mask) return '0;
    return cms_pkg::METRIC_W'((gx + gy) * 2 + ((gx < gy) ? 1 : 0));
  endfunction

  task automatic sobel_predict(input pix_item_t it);
    int unsigned               w, h, c;
    bit                        draining;
    logic [cms_pkg::PIX_W-1:0] u, m, om;
    cms_pkg::col_t             cur;
    cms_pkg::res_t             r;
    w = eff_width();
    h = eff_height();
    draining = (row_pos >= h);
    // An early drain flag is dropped without touching any state.
    if (!draining && it.drain) return;
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    u = upper_mem[c];
    m = middle_mem[c];
    om = maskrow_mem[c];
    if (!draining) begin
      upper_mem[c] = m;
      middle_mem[c] = it.pixel;
      maskrow_mem[c] = it.mask;
    end
    cur.top = (row_pos <= 1) ? m : u;
    cur.mid = m;
    cur.bot = draining ? m : it.pixel;
    if (row_pos >= 1 && c >= 1) begin
      r.metric = sobel_metric((c == 1) ? win_col[0] : win_col[1], win_col[0], cur, mask_dly);
      r.frame_last = 1'b0;
      metric_pending.push_back(r);
    end
    if (row_pos >= 1 && c == w - 1) begin
      r.metric = sobel_metric(win_col[0], cur, cur, om);
      r.frame_last = draining;
      metric_pending.push_back(r);
    end
    win_col[1] = win_col[0];
    win_col[0] = cur;
    mask_dly = om;
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = draining ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_MAX)
      $display("t=%0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [cms_pkg::PIX_W-1:0] rand_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return cms_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  // Monitor: configuration, input prediction, result checking and the watchdog.
  always @(posedge clk) begin : monitor
    bit            cfg_fire, res_fire;
    cms_pkg::res_t want;
    cfg_fire = cfg_if.valid && cfg_if.ready;
    pix_taken = pix_if.valid && pix_if.ready;
    res_fire = res_if.valid && res_if.ready;
    if (cfg_fire) begin
      unique case (cms_pkg::cfg_reg_e'(cfg_if.index))
        cms_pkg::CFG_IMAGE_WIDTH:  cfg_width = cfg_if.data[cms_pkg::WIDTH_W-1:0];
        cms_pkg::CFG_IMAGE_HEIGHT: cfg_height = cfg_if.data[cms_pkg::HEIGHT_W-1:0];
        cms_pkg::CFG_MIN_MASK:     cfg_min_mask = cfg_if.data[cms_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
    if (pix_taken)
      sobel_predict('{pixel: pix_if.pixel_value, mask: pix_if.mask_value, drain: pix_if.drain});
    if (res_fire) begin
      if (metric_pending.size() == 0) begin
        report_mismatch("result with nothing pending, metric", res_if.metric, -1);
      end else begin
        want = metric_pending.pop_front();
        if (res_if.metric !== want.metric)
          report_mismatch("metric", res_if.metric, want.metric);
        if (res_if.frame_last !== want.frame_last)
          report_mismatch("frame_last", res_if.frame_last, want.frame_last);
      end
    end
    if (cfg_fire || pix_taken || res_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Pixel driver, fed from the pending queue.
  always @(negedge clk) begin : pix_driver
    pix_item_t it;
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else if (pix_if.valid && !pix_taken) begin
      // Offer stays in place until it is taken.
    end else if (pix_wait > 0) begin
      pix_if.valid <= 1'b0;
      pix_wait--;
    end else if (pix_pending.size() != 0) begin
      it = pix_pending.pop_front();
      pix_if.valid <= 1'b1;
      pix_if.pixel_value <= it.pixel;
      pix_if.mask_value <= it.mask;
      pix_if.drain <= it.drain;
      pix_wait = pix_idle_on ? idle_len() : 0;
    end else begin
      pix_if.valid <= 1'b0;
    end
  end

  // Result sink with random stalls and one long hold-off.
  always @(negedge clk) begin : res_sink
    if (!rst_n || hold_res) begin
      res_if.ready <= 1'b0;
    end else if (res_wait > 0) begin
      res_if.ready <= 1'b0;
      res_wait--;
    end else begin
      res_if.ready <= 1'b1;
      if (res_idle_on && $urandom_range(0, 99) < 20) res_wait = idle_len();
    end
  end

  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    hold_res = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_res = 1'b0;
  end

  // Queues one item and advances the generator's scan position the way the block does.
  task automatic push_item(input logic [cms_pkg::PIX_W-1:0] px,
                           input logic [cms_pkg::PIX_W-1:0] mk, input logic dr);
    int unsigned w, c;
    bit          draining;
    pix_pending.push_back('{pixel: px, mask: mk, drain: dr});
    w = eff_width();
    draining = (gen_row >= eff_height());
    if (!draining && dr) return;
    c = (gen_col > w - 1) ? w - 1 : gen_col;
    if (c >= w - 1) begin
      gen_col = 0;
      gen_row = draining ? 0 : gen_row + 1;
    end else begin
      gen_col = c + 1;
    end
  endtask

  task automatic gen_one();
    bit draining;
    draining = (gen_row >= eff_height());
    if (!draining && $urandom_range(0, 24) == 0) push_item(rand_byte(), rand_byte(), 1'b1);
    if (draining) push_item(rand_byte(), rand_byte(), $urandom_range(0, 7) != 0);
    else push_item(rand_byte(), rand_byte(), 1'b0);
    items_made++;
  endtask

  task automatic gen_stream(input int unsigned n);
    repeat (n) gen_one();
  endtask

  task automatic finish_frame();
    do gen_one(); while (gen_row != 0 || gen_col != 0);
  endtask

  task automatic write_reg(input cms_pkg::cfg_reg_e idx,
                           input logic [cms_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until the sender is empty, every pending result has arrived and the pipe is quiet.
  task automatic settle();
    while (pix_pending.size() != 0 || pix_if.valid) @(posedge clk);
    while (metric_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_PAD) @(posedge clk);
  endtask

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 1);
    if (r < 75) return $urandom_range(2, 10);
    if (r < 95) return $urandom_range(11, 40);
    return $urandom_range(41, 120);
  endfunction

  function automatic int unsigned pick_height();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 85) return $urandom_range(1, 5);
    return $urandom_range(6, 16);
  endfunction

  function automatic int unsigned pick_min_mask();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 55) return 255;
    return $urandom_range(1, 254);
  endfunction

  // In mid-frame the width never grows, so no line entry is read before it is written.
  task automatic new_settings();
    bit mid;
    mid = (gen_row != 0) || (gen_col != 0);
    if (!mid) write_reg(cms_pkg::CFG_IMAGE_WIDTH, cms_pkg::CFG_DATA_W'(pick_width()));
    else if ($urandom_range(0, 2) == 0)
      write_reg(cms_pkg::CFG_IMAGE_WIDTH,
                cms_pkg::CFG_DATA_W'($urandom_range(0, eff_width())));
    if (!mid || $urandom_range(0, 1) == 0)
      write_reg(cms_pkg::CFG_IMAGE_HEIGHT, cms_pkg::CFG_DATA_W'(pick_height()));
    if ($urandom_range(0, 2) != 0)
      write_reg(cms_pkg::CFG_MIN_MASK, cms_pkg::CFG_DATA_W'(pick_min_mask()));
  endtask

  initial begin : main
    int unsigned made_base;
    rst_n = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = cms_pkg::CFG_IMAGE_WIDTH;
    cfg_if.data = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel_value = '0;
    pix_if.mask_value = '0;
    pix_if.drain = 1'b0;
    res_if.ready = 1'b0;
    win_col[0] = '0;
    win_col[1] = '0;
    for (int i = 0; i < cms_pkg::MAX_WIDTH_DEF; i++) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
      maskrow_mem[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Small frame with masking at the threshold, an early drain flag and a pixel in the flush row.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd3);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(cms_pkg::CFG_MIN_MASK, 16'd128);
    push_item(8'd255, 8'd0, 1'b0);
    push_item(8'd0, 8'd127, 1'b0);
    push_item(8'd255, 8'd128, 1'b0);
    push_item(8'd0, 8'd255, 1'b0);
    push_item(8'd255, 8'd200, 1'b0);
    push_item(8'd9, 8'd9, 1'b1);
    push_item(8'd0, 8'd128, 1'b0);
    push_item(8'd0, 8'd0, 1'b1);
    push_item(8'd77, 8'd5, 1'b0);
    push_item(8'd255, 8'd255, 1'b1);
    settle();

    // Width below the minimum, height zero and the highest mask threshold.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd1);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    write_reg(cms_pkg::CFG_MIN_MASK, 16'd255);
    push_item(8'd255, 8'd255, 1'b0);
    push_item(8'd0, 8'd254, 1'b0);
    push_item(8'd0, 8'd0, 1'b1);
    push_item(8'd255, 8'd255, 1'b1);
    settle();

    // Width cut below the current column in mid-row ends that row at once.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd6);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    write_reg(cms_pkg::CFG_MIN_MASK, 16'd0);
    gen_stream(10);
    settle();
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd3);
    finish_frame();
    settle();

    // Largest height, then a cut below the current row, which starts the flush.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd2);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd65535);
    gen_stream(14);
    settle();
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd1);
    finish_frame();
    settle();

    // The sink holds off while the sender keeps offering, so the block fills and stalls.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd16);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd10);
    pix_idle_on = 1'b0;
    res_idle_on = 1'b0;
    hold_go = 1'b1;
    finish_frame();
    settle();

    // The largest width register value clamps to the line length; a cut in mid-row ends the row.
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd8191);
    write_reg(cms_pkg::CFG_IMAGE_HEIGHT, 16'd1);
    res_idle_on = 1'b1;
    gen_stream(20);
    settle();
    write_reg(cms_pkg::CFG_IMAGE_WIDTH, 16'd3);
    finish_frame();
    settle();

    // Random settings; some phases stop in mid-frame and the next settings apply there.
    made_base = items_made;
    while (items_made - made_base < RAND_ITEMS) begin
      new_settings();
      pix_idle_on = ($urandom_range(0, 3) != 0);
      res_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) gen_stream($urandom_range(3, 40));
      else finish_frame();
      settle();
    end
    repeat (2 * SETTLE_PAD) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
